[rtl/core/nlig_pkg.sv]
// Shared types and codes of the nested loop index generator.
package nlig_pkg;

    typedef enum logic [1:0] {
        FUNC_LOAD     = 2'd0,
        FUNC_RESTART  = 2'd1,
        FUNC_NEXT     = 2'd2,
        FUNC_CONTINUE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_VALUE     = 2'd0,
        STATUS_DONE      = 2'd1,
        STATUS_ZERO_STEP = 2'd2,
        STATUS_LOAD_ACK  = 2'd3
    } status_t;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_CHK_RD  = 12'b0000_0000_0010,
        ST_CHK_EX  = 12'b0000_0000_0100,
        ST_INIT_RD = 12'b0000_0000_1000,
        ST_INIT_EX = 12'b0000_0001_0000,
        ST_RST_RD  = 12'b0000_0010_0000,
        ST_RST_EX  = 12'b0000_0100_0000,
        ST_ADV_RD  = 12'b0000_1000_0000,
        ST_ADV_EX  = 12'b0001_0000_0000,
        ST_EMIT_RD = 12'b0010_0000_0000,
        ST_EMIT_EX = 12'b0100_0000_0000,
        ST_FIN     = 12'b1000_0000_0000
    } state_t;

endpackage

[rtl/core/nested_loop_index_generator.sv]
// A load is acknowledged in the cycle after it is taken; a restart only clears the running nest.
// A next or continue scans the active levels, then returns one result (done or zero step), or,
// if the nest is not running, emits the start of every level, or resets deeper levels, walks
// the carry and emits the tuple, one level at a time through the shared adder and comparators,
// as the level tables have a single read port; a new request waits until the last is through.
// Reset (rst_n, asynchronous, active low) clears control state; the level tables are undefined.
module nested_loop_index_generator
    import nlig_pkg::*;
#(
    parameter int LEVELS      = 8,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [3:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [2:0]         level,
    input  logic signed [31:0] start_value,
    input  logic signed [31:0] end_value,
    input  logic signed [31:0] step_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         out_level,
    output logic signed [31:0] out_value,
    output logic               last_of_tuple,
    output logic [1:0]         status
);

    localparam int VW = VALUE_WIDTH;
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW = $clog2(LEVELS + 1);

    // Level tables and current counter values.
    logic signed [VW-1:0] start_mem [LEVELS];
    logic signed [VW-1:0] end_mem   [LEVELS];
    logic signed [VW-1:0] step_mem  [LEVELS];
    logic signed [VW-1:0] cur_mem   [LEVELS];

    logic signed [VW-1:0] start_rd_reg;
    logic signed [VW-1:0] end_rd_reg;
    logic signed [VW-1:0] step_rd_reg;
    logic signed [VW-1:0] cur_rd_reg;

    state_t          state_reg, state_next;
    logic [3:0]      cfg_reg;
    logic            running_reg, running_next;
    logic            empty_reg, empty_next;
    logic [LW-1:0]   idx_reg, idx_next;
    logic [LW-1:0]   p_reg, p_next;
    logic [1:0]      func_reg, func_next;
    logic [2:0]      lvl_reg, lvl_next;
    logic [2:0]      fin_level_reg, fin_level_next;
    logic [1:0]      fin_status_reg, fin_status_next;

    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_level_reg, out_level_next;
    logic signed [31:0] out_value_reg, out_value_next;
    logic               out_last_reg, out_last_next;
    logic [1:0]         out_status_reg, out_status_next;

    logic [CW-1:0]   n_act;
    logic [CW-1:0]   n_m1;
    logic            idx_last;
    logic            out_free;
    logic            accept;
    logic            tbl_we;
    logic            cur_we;
    logic signed [VW-1:0] cur_wdata;
    logic [VW:0]     adv_sum;
    logic signed [VW-1:0] adv_value;
    logic            adv_ok;
    logic            start_in_range;
    logic            use_lvl;
    logic [LW-1:0]   p_sel;

    // Active level count: zero acts as one, and values above LEVELS act as LEVELS.
    always_comb
    begin
        if (cfg_reg == 4'd0)
        begin
            n_act = CW'(1);
        end
        else if ({4'b0000, cfg_reg} > 8'(LEVELS))
        begin
            n_act = CW'(LEVELS);
        end
        else
        begin
            n_act = CW'(cfg_reg);
        end
    end

    assign n_m1     = n_act - CW'(1);
    assign idx_last = (CW'(idx_reg) == n_m1);
    assign out_free = !out_valid_reg || !out_stall;
    assign accept   = in_valid && !in_stall;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);
    assign tbl_we   = accept && (func == FUNC_LOAD) && ({5'b00000, level} < 8'(LEVELS));

    // Shared adder and comparator. Signed overflow counts as passing the end.
    assign adv_sum   = {cur_rd_reg[VW-1], cur_rd_reg} + {step_rd_reg[VW-1], step_rd_reg};
    assign adv_value = signed'(adv_sum[VW-1:0]);
    assign adv_ok    = (adv_sum[VW] == adv_sum[VW-1]) &&
                       (step_rd_reg[VW-1] ? (adv_value >= end_rd_reg)
                                          : (adv_value <= end_rd_reg));
    assign start_in_range = step_rd_reg[VW-1] ? (start_rd_reg >= end_rd_reg)
                                              : (start_rd_reg <= end_rd_reg);

    // A continue beyond the active levels behaves as a next.
    assign use_lvl = (func_reg == FUNC_CONTINUE) && ({5'b00000, lvl_reg} < 8'(n_act));
    assign p_sel   = use_lvl ? LW'(lvl_reg) : LW'(n_m1);

    always_comb
    begin
        state_next      = state_reg;
        running_next    = running_reg;
        empty_next      = empty_reg;
        idx_next        = idx_reg;
        p_next          = p_reg;
        func_next       = func_reg;
        lvl_next        = lvl_reg;
        fin_level_next  = fin_level_reg;
        fin_status_next = fin_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_level_next  = out_level_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        cur_we          = 1'b0;
        cur_wdata       = start_rd_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next = func;
                    lvl_next  = level;
                    case (func)
                        FUNC_LOAD:
                        begin
                            running_next    = 1'b0;
                            out_valid_next  = 1'b1;
                            out_level_next  = level;
                            out_value_next  = start_value;
                            out_last_next   = 1'b1;
                            out_status_next = STATUS_LOAD_ACK;
                        end
                        FUNC_RESTART:
                        begin
                            running_next = 1'b0;
                        end
                        default:
                        begin
                            idx_next   = '0;
                            empty_next = 1'b0;
                            state_next = ST_CHK_RD;
                        end
                    endcase
                end
            end
            ST_CHK_RD:
            begin
                state_next = ST_CHK_EX;
            end
            ST_CHK_EX:
            begin
                // A zero step wins over an empty range at any level.
                if (step_rd_reg == '0)
                begin
                    fin_level_next  = 3'(idx_reg);
                    fin_status_next = STATUS_ZERO_STEP;
                    state_next      = ST_FIN;
                end
                else if (!idx_last)
                begin
                    empty_next = empty_reg || !start_in_range;
                    idx_next   = idx_reg + LW'(1);
                    state_next = ST_CHK_RD;
                end
                else if (empty_reg || !start_in_range)
                begin
                    fin_level_next  = 3'd0;
                    fin_status_next = STATUS_DONE;
                    state_next      = ST_FIN;
                end
                else if (!running_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_INIT_RD;
                end
                else
                begin
                    p_next = p_sel;
                    if (CW'(p_sel) != n_m1)
                    begin
                        idx_next   = LW'(n_m1);
                        state_next = ST_RST_RD;
                    end
                    else
                    begin
                        idx_next   = p_sel;
                        state_next = ST_ADV_RD;
                    end
                end
            end
            ST_INIT_RD:
            begin
                state_next = ST_INIT_EX;
            end
            ST_INIT_EX:
            begin
                if (out_free)
                begin
                    cur_we          = 1'b1;
                    out_valid_next  = 1'b1;
                    out_level_next  = 3'(idx_reg);
                    out_value_next  = 32'(start_rd_reg);
                    out_last_next   = idx_last;
                    out_status_next = STATUS_VALUE;
                    if (idx_last)
                    begin
                        running_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + LW'(1);
                        state_next = ST_INIT_RD;
                    end
                end
            end
            ST_RST_RD:
            begin
                state_next = ST_RST_EX;
            end
            ST_RST_EX:
            begin
                // Levels deeper than the continued one go back to their starts.
                cur_we = 1'b1;
                if (idx_reg == p_reg + LW'(1))
                begin
                    idx_next   = p_reg;
                    state_next = ST_ADV_RD;
                end
                else
                begin
                    idx_next   = idx_reg - LW'(1);
                    state_next = ST_RST_RD;
                end
            end
            ST_ADV_RD:
            begin
                state_next = ST_ADV_EX;
            end
            ST_ADV_EX:
            begin
                cur_we = 1'b1;
                if (adv_ok)
                begin
                    cur_wdata  = adv_value;
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                end
                else if (idx_reg == '0)
                begin
                    fin_level_next  = 3'd0;
                    fin_status_next = STATUS_DONE;
                    state_next      = ST_FIN;
                end
                else
                begin
                    idx_next   = idx_reg - LW'(1);
                    state_next = ST_ADV_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_EX;
            end
            ST_EMIT_EX:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_level_next  = 3'(idx_reg);
                    out_value_next  = 32'(cur_rd_reg);
                    out_last_next   = idx_last;
                    out_status_next = STATUS_VALUE;
                    if (idx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + LW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_level_next  = fin_level_reg;
                    out_value_next  = '0;
                    out_last_next   = 1'b1;
                    out_status_next = fin_status_reg;
                    if (fin_status_reg == STATUS_DONE)
                    begin
                        running_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A register write restarts the nest.
        if (cfg_wr_en)
        begin
            running_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_reg       <= 4'd1;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        empty_reg      <= empty_next;
        idx_reg        <= idx_next;
        p_reg          <= p_next;
        func_reg       <= func_next;
        lvl_reg        <= lvl_next;
        fin_level_reg  <= fin_level_next;
        fin_status_reg <= fin_status_next;
        out_level_reg  <= out_level_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            start_mem[LW'(level)] <= VW'(start_value);
            end_mem[LW'(level)]   <= VW'(end_value);
            step_mem[LW'(level)]  <= VW'(step_value);
        end
        if (cur_we)
        begin
            cur_mem[idx_reg] <= cur_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        start_rd_reg <= start_mem[idx_reg];
        end_rd_reg   <= end_mem[idx_reg];
        step_rd_reg  <= step_mem[idx_reg];
        cur_rd_reg   <= cur_mem[idx_reg];
    end

    assign out_valid     = out_valid_reg;
    assign out_level     = out_level_reg;
    assign out_value     = out_value_reg;
    assign last_of_tuple = out_last_reg;
    assign status        = out_status_reg;

`ifndef SYNTH
    a_single_results_are_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_VALUE) |-> last_of_tuple)
        else $error("single result without last mark");

    a_load_acked: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (func == FUNC_LOAD) |=> out_valid && (status == STATUS_LOAD_ACK))
        else $error("load not acknowledged in the next cycle");

    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && (status == STATUS_DONE) |=> !running_reg)
        else $error("nest still running after done");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (CW'(idx_reg) < n_act))
        else $error("level index beyond active levels");
`endif

endmodule
